### design/tpg_pkg.sv
`timescale 1ns / 1ps

package tpg_pkg;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_SPEED = 1'b1;

   localparam logic [15:0] SPEED_CORR_MIN = 16'd1000;
   localparam logic [15:0] SPEED_STOP_MIN = 16'd400;
   localparam logic [17:0] SPEED_CORR_DIV = 18'd144000;

   // 144000 = 128 * 1125: drop 7 bits, then multiply by ceil(2^36 / 1125)
   // and keep bits [50:36]; exact for every 25-bit dividend
   localparam logic [25:0] CORR_RECIP = 26'd61083980;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [5:0] DIVIDE_RESET = 6'd1;
   localparam logic [7:0] TOP_MAX      = 8'd255;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SQUARE = 8'b0000_0010,
      ST_CORR   = 8'b0000_0100,
      ST_ADJUST = 8'b0000_1000,
      ST_BAND   = 8'b0001_0000,
      ST_QUOT   = 8'b0010_0000,
      ST_STORE  = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic [5:0]  divisor;
      logic [20:0] numer;
   } band_type;

   function automatic band_type band_lookup(input logic [15:0] speed);
      band_type b;
      priority if (speed >= 16'd4900) begin
         b.divisor = 6'd3;  b.numer = 21'd1250000;
      end else if (speed >= 16'd3700) begin
         b.divisor = 6'd4;  b.numer = 21'd937500;
      end else if (speed >= 16'd2500) begin
         b.divisor = 6'd6;  b.numer = 21'd625000;
      end else if (speed >= 16'd1850) begin
         b.divisor = 6'd8;  b.numer = 21'd468750;
      end else if (speed >= 16'd1250) begin
         b.divisor = 6'd12; b.numer = 21'd312500;
      end else if (speed >= 16'd950) begin
         b.divisor = 6'd16; b.numer = 21'd234375;
      end else if (speed >= 16'd600) begin
         b.divisor = 6'd24; b.numer = 21'd156250;
      end else begin
         b.divisor = 6'd32; b.numer = 21'd117187;
      end
      return b;
   endfunction

endpackage

### design/tacho_pulse_generator_unit.sv
`timescale 1ns / 1ps
// Tachometer pulse generator.
// Input stream (req_): one word per item. req_tuser selects the kind:
//   0 = one prescaled timer tick, 1 = set speed with req_tdata as rpm.
// Result stream (rsp_): one word per input word, carrying the output pin
//   level, the running flag, the compare top and the matches per toggle.
// A tick word's result is registered in the cycle after the word is taken. A
//   set-speed word runs a small sequencer: above 1000 rpm one shared multiplier
//   squares the speed and then scales it by a reciprocal for the correction,
//   and a 32-step restoring divider finds the band quotient. At or below
//   1000 rpm the correction is skipped. Under 400 rpm (stop) the divider is
//   skipped too and the sequencer goes straight to its finish state.
// Throughput: one word at a time; ticks can run every cycle while the
//   result side keeps up.
// The result register frees the input side: a new word is taken while the
//   previous result waits, as long as that result is taken in the same cycle
//   or the register is empty. If rsp_tready stays low, the result holds and
//   req_tready drops until it is taken.
// Reset (synchronous, active high) stops the timer, drives the pin low,
//   clears the counters and the compare top and sets the divide to one.
module tacho_pulse_generator_unit
   import tpg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] rpm
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] tacho_level, [1] running,
                                    // [9:2] compare_top, [15:10] pulse_divide
);

   state_type state_ff, state_in;

   logic [7:0]  tick_count_ff, tick_count_in;
   logic [5:0]  match_count_ff, match_count_in;
   logic [7:0]  top_value_ff, top_value_in;
   logic [5:0]  divide_limit_ff, divide_limit_in;
   logic        timer_on_ff, timer_on_in;
   logic        pin_level_ff, pin_level_in;

   logic [15:0] speed_ff, speed_in;
   logic [5:0]  band_div_ff, band_div_in;

   // shared divider
   logic [31:0] div_q_ff, div_q_in;
   logic [17:0] div_r_ff, div_r_in;
   logic [17:0] div_d_ff, div_d_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic [18:0] div_shift;
   logic        div_ge;
   logic [17:0] div_rem_next;
   logic        div_last;

   // shared multiplier
   logic [24:0] mul_a;
   logic [25:0] mul_b;
   logic [50:0] mul_p;

   logic        out_free;
   logic [7:0]  tick_next;
   logic [5:0]  match_inc;
   logic [7:0]  tick_new;
   logic [5:0]  match_new;
   logic        pin_new;
   band_type    band;
   logic [31:0] quot_m1;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one restoring step
   assign div_shift    = {1'b0, div_r_ff} << 1 | {18'd0, div_q_ff[31]};
   assign div_ge       = div_shift >= {1'b0, div_d_ff};
   assign div_rem_next = div_ge ? 18'(div_shift - {1'b0, div_d_ff}) : div_shift[17:0];
   assign div_last     = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   // square of the speed, then square/128 times the reciprocal of 1125
   assign mul_a = (state_ff == ST_SQUARE) ? {9'd0, speed_ff} : div_q_ff[31:7];
   assign mul_b = (state_ff == ST_SQUARE) ? {10'd0, speed_ff} : CORR_RECIP;
   assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

   assign band    = band_lookup(speed_ff);
   assign quot_m1 = (div_q_ff == 32'd0) ? 32'd0 : div_q_ff - 32'd1;

   // timer tick
   always_comb begin
      tick_new  = tick_count_ff;
      match_new = match_count_ff;
      pin_new   = pin_level_ff;
      tick_next = (tick_count_ff == top_value_ff) ? 8'd0 : tick_count_ff + 8'd1;
      match_inc = match_count_ff + 6'd1;
      if (timer_on_ff) begin
         tick_new = tick_next;
         if (tick_next == top_value_ff) begin
            match_new = match_inc;
            if (match_inc >= divide_limit_ff) begin
               pin_new   = !pin_level_ff;
               match_new = 6'd0;
            end
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      tick_count_in   = tick_count_ff;
      match_count_in  = match_count_ff;
      top_value_in    = top_value_ff;
      divide_limit_in = divide_limit_ff;
      timer_on_in     = timer_on_ff;
      pin_level_in    = pin_level_ff;
      speed_in        = speed_ff;
      band_div_in     = band_div_ff;
      div_q_in        = div_q_ff;
      div_r_in        = div_r_ff;
      div_d_in        = div_d_ff;
      div_cnt_in      = div_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_tuser == OP_SPEED) begin
                  speed_in = req_tdata;
                  state_in = (req_tdata > SPEED_CORR_MIN) ? ST_SQUARE : ST_BAND;
               end else begin
                  tick_count_in  = tick_new;
                  match_count_in = match_new;
                  pin_level_in   = pin_new;
                  rsp_valid_in   = 1'b1;
                  rsp_data_in    = {divide_limit_ff, top_value_ff, timer_on_ff, pin_new};
               end
            end
         end
         ST_SQUARE: begin
            div_q_in = mul_p[31:0];
            state_in = ST_CORR;
         end
         ST_CORR: begin
            div_q_in = {17'd0, mul_p[50:36]};
            state_in = ST_ADJUST;
         end
         ST_ADJUST: begin
            // correction is always below the speed in range; kept as a guard
            if ({16'd0, speed_ff} > div_q_ff) begin
               speed_in = speed_ff - div_q_ff[15:0];
            end
            state_in = ST_BAND;
         end
         ST_BAND: begin
            if (speed_ff < SPEED_STOP_MIN) begin
               timer_on_in  = 1'b0;
               pin_level_in = 1'b0;
               state_in     = ST_FINISH;
            end else begin
               div_q_in    = {11'd0, band.numer};
               div_r_in    = 18'd0;
               div_d_in    = {2'd0, speed_ff};
               div_cnt_in  = '0;
               band_div_in = band.divisor;
               state_in    = ST_QUOT;
            end
         end
         ST_QUOT: begin
            div_q_in   = {div_q_ff[30:0], div_ge};
            div_r_in   = div_rem_next;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            top_value_in    = (quot_m1 > {24'd0, TOP_MAX}) ? TOP_MAX : quot_m1[7:0];
            divide_limit_in = band_div_ff;
            timer_on_in     = 1'b1;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {divide_limit_ff, top_value_ff, timer_on_ff, pin_level_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tick_count_ff   <= 8'd0;
         match_count_ff  <= 6'd0;
         top_value_ff    <= 8'd0;
         divide_limit_ff <= DIVIDE_RESET;
         timer_on_ff     <= 1'b0;
         pin_level_ff    <= 1'b0;
         div_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tick_count_ff   <= tick_count_in;
         match_count_ff  <= match_count_in;
         top_value_ff    <= top_value_in;
         divide_limit_ff <= divide_limit_in;
         timer_on_ff     <= timer_on_in;
         pin_level_ff    <= pin_level_in;
         div_cnt_ff      <= div_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      speed_ff    <= speed_in;
      band_div_ff <= band_div_in;
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      div_d_ff    <= div_d_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### design/tpg_checker.sv
`timescale 1ns / 1ps
module tpg_checker
   import tpg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic [5:0] chk_divide;
   assign chk_divide = rsp_tdata[15:10];

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // a stalled input word holds
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("input word changed while stalled");

   // pulse divide is the reset value or one of the band divisors
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (chk_divide == DIVIDE_RESET || chk_divide == 6'd3 ||
                      chk_divide == 6'd4 || chk_divide == 6'd6 || chk_divide == 6'd8 ||
                      chk_divide == 6'd12 || chk_divide == 6'd16 ||
                      chk_divide == 6'd24 || chk_divide == 6'd32))
      else $error("pulse divide out of band set");

   // a stopped timer keeps the pin low
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("pin high while timer stopped");

   // no result word right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind tacho_pulse_generator_unit tpg_checker u_tpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
